/* src/wlit_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and tables of the inverse-time step unit.
package wlit_pkg;

  localparam int BIN_DEPTH   = 1024;
  localparam int FRAC_BITS   = 24;
  localparam int BIN_W       = $clog2(BIN_DEPTH);
  localparam int NB_W        = $clog2(BIN_DEPTH + 1);
  localparam int LD_W        = 24 + FRAC_BITS;
  localparam int DVD_W       = (NB_W + FRAC_BITS > 32) ? (NB_W + FRAC_BITS) : 32;
  localparam int BIN_FIELD_W = 10;
  localparam int CNT_W       = 32;
  localparam int MOD_W       = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int MUL_W       = 33;

  localparam logic [31:0] STEP_LIMIT  = 32'd4000000000;
  localparam logic [31:0] EXP_M1_Q32  = 32'd1580030169;
  localparam logic [LD_W-1:0] EXP_CUT = LD_W'(23) << FRAC_BITS;

  localparam logic [10:0] RST_BINS      = 11'd1024;
  localparam logic [9:0]  RST_START     = 10'd0;
  localparam logic [31:0] RST_INIT_MOD  = 32'd16777216;
  localparam logic [31:0] RST_INTERVAL  = 32'd1000;
  localparam logic [31:0] RST_THRESHOLD = 32'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_IN_USE = 3'd0,
    CFG_START_BIN   = 3'd1,
    CFG_INIT_MOD    = 3'd2,
    CFG_INTERVAL    = 3'd3,
    CFG_THRESHOLD   = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_OLD, S_RD_NEW, S_CMP, S_E_MUL1, S_E_MUL2, S_E_DIV,
    S_E_POW, S_E_POW2, S_UPD_A, S_UPD_W, S_TWAIT, S_MWAIT, S_SWEEP, S_VCLR,
    S_MODCHK, S_FIN, S_OUT
  } st_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
    logic [31:0]      remainder;
  } div_rsp_t;

  // floor(2^32 / k), Q1.32 reciprocal of the series index
  function automatic logic [MUL_W-1:0] recip(input logic [3:0] k);
    logic [MUL_W-1:0] m;
    unique case (k)
      4'd1:    m = 33'h1_0000_0000;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      4'd11:   m = 33'd390451572;
      4'd12:   m = 33'd357913941;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* src/wlit_in_if.sv */
`timescale 1ns / 1ps
// Input channel: proposed bin and uniform random number.
interface wlit_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] proposed_bin;
  logic [31:0] random_uniform;
  modport source (output valid, output proposed_bin, output random_uniform, input ready);
  modport sink (input valid, input proposed_bin, input random_uniform, output ready);
endinterface

/* src/wlit_out_if.sv */
`timescale 1ns / 1ps
// Result channel: step outcome and run status.
interface wlit_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [9:0]  current_bin;
  logic        inverse_time_phase;
  logic        converged;
  logic        limit_reached;
  logic [31:0] modification_now;
  modport source (output valid, output accepted, output current_bin,
                  output inverse_time_phase, output converged, output limit_reached,
                  output modification_now, input ready);
  modport sink (input valid, input accepted, input current_bin,
                input inverse_time_phase, input converged, input limit_reached,
                input modification_now, output ready);
endinterface

/* src/wlit_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wlit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/wlit_mul.sv */
`timescale 1ns / 1ps
// Shared 33x33 multiplier with registered product.
module wlit_mul (
  input  logic                           clk,
  input  logic [wlit_pkg::MUL_W-1:0]     a,
  input  logic [wlit_pkg::MUL_W-1:0]     b,
  output logic [2*wlit_pkg::MUL_W-1:0]   prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

/* src/wlit_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module wlit_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wlit_pkg::div_req_t  req,
  output wlit_pkg::div_rsp_t  rsp
);
  localparam int CW = $clog2(wlit_pkg::DVD_W + 1);

  logic                       busy_r;
  logic [CW-1:0]              cnt_r;
  logic [wlit_pkg::DVD_W-1:0] dvd_r;
  logic [wlit_pkg::DVD_W-1:0] quo_r;
  logic [31:0]                rem_r;
  logic [31:0]                dvs_r;
  logic [32:0]                trial;
  logic                       fits;

  assign trial = {rem_r, dvd_r[wlit_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(wlit_pkg::DVD_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      quo_r <= {quo_r[wlit_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;
endmodule

/* src/wang_landau_inverse_time_step_unit.sv */
`timescale 1ns / 1ps
// Top level: inverse-time Wang-Landau step sequencer around shared arithmetic.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | proposed_bin, random_uniform
//  out_ch  | out | valid/ready   | accepted, current_bin, phase, converged, limit, factor
//  cfg     | in  | cfg_we        | cfg_idx, cfg_wdata
//
// One item at a time; once the run is finished an item passes straight to the output.
// Otherwise it waits on the divider for bins/steps and, in the halving phase, on its
// second pass for the check-interval remainder; the exp series, with a further
// multiply per unit of the integer part of the log-density gap, overlaps the first pass.
// A check sweep reads the visit counts of the bins in use; a successful one clears them all.
// After reset a clearing pass over all 1024 bins runs before the first transfer.
// A result waiting on out_ch stalls only the end of the next item.
module wang_landau_inverse_time_step_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wlit_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wlit_pkg::CFG_W-1:0]     cfg_wdata,
  wlit_in_if.sink                        in_ch,
  wlit_out_if.source                     out_ch
);
  localparam int BW = wlit_pkg::BIN_W;
  localparam int NW = wlit_pkg::NB_W;
  localparam int LW = wlit_pkg::LD_W;
  localparam int F  = wlit_pkg::FRAC_BITS;
  localparam int MW = wlit_pkg::MUL_W;

  wlit_pkg::st_t st_r, st_nxt;

  logic [10:0] bins_r;
  logic [31:0] occ_r, thr_r;
  logic        pristine_r;

  logic [9:0]  pres_r, prop_r;
  logic [31:0] rnd_r, mod_r, step_r, t_r, a_r, f_r;
  logic        phase_r, done_r, acc_r, chkv_r;
  logic [LW-1:0] so_r;
  logic [4:0]  n_r;
  logic [MW-1:0] p_r;
  logic [3:0]  k_r;
  logic [BW-1:0] clr_r;
  logic [NW-1:0] swp_r;

  logic        ov_r, o_acc_r, o_phase_r, o_conv_r, o_lim_r;
  logic [9:0]  o_bin_r;
  logic [31:0] o_mod_r;

  logic          ld_we, vc_we;
  logic [BW-1:0] ld_wa, ld_ra, vc_wa, vc_ra;
  logic [LW-1:0] ld_wd, ld_q;
  logic [31:0]   vc_wd, vc_q;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] prod_q;
  wlit_pkg::div_req_t dreq;
  wlit_pkg::div_rsp_t drsp;

  logic [31:0]   nb32;
  logic [NW-1:0] nb;
  logic          in_acc, run_ok, prop_hi, exp_go, last_clr;
  logic          sweep_fail, sweep_ok, out_free;
  logic [LW-1:0] d_w;
  logic [LW:0]   ld_sum;
  logic [31:0]   q0, q_fix, iv, t_w;
  logic [35:0]   qk;
  logic [31:0]   rem_w;

  assign nb32 = (bins_r == 11'd0) ? 32'd1 :
                (32'(bins_r) > 32'(wlit_pkg::BIN_DEPTH)) ? 32'(wlit_pkg::BIN_DEPTH) :
                32'(bins_r);
  assign nb       = NW'(nb32);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign run_ok   = !done_r && (step_r < wlit_pkg::STEP_LIMIT);
  assign prop_hi  = 32'(prop_r) >= nb32;
  assign d_w      = ld_q - so_r;
  assign exp_go   = !prop_hi && (ld_q > so_r) && (d_w < wlit_pkg::EXP_CUT);
  assign last_clr = clr_r == BW'(wlit_pkg::BIN_DEPTH - 1);
  assign sweep_fail = chkv_r && (vc_q == 32'd0);
  assign sweep_ok   = !sweep_fail && (swp_r == nb);
  assign out_free   = !ov_r || out_ch.ready;
  assign ld_sum   = {1'b0, ld_q} + (LW + 1)'(mod_r);
  assign q0       = prod_q[63:32];
  assign qk       = 36'(q0) * 36'(k_r);
  assign rem_w    = a_r - qk[31:0];
  assign q_fix    = (rem_w >= 32'(k_r)) ? q0 + 32'd1 : q0;
  assign iv       = (occ_r == 32'd0) ? 32'd1 : occ_r;
  assign t_w      = (step_r == 32'd0) ? 32'hFFFF_FFFF :
                    (64'(drsp.quotient) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF :
                    drsp.quotient[31:0];

  wlit_ram #(.WIDTH(LW), .DEPTH(wlit_pkg::BIN_DEPTH)) u_ld_ram (
    .clk(clk), .we(ld_we), .waddr(ld_wa), .wdata(ld_wd), .raddr(ld_ra), .rdata(ld_q)
  );
  wlit_ram #(.WIDTH(32), .DEPTH(wlit_pkg::BIN_DEPTH)) u_vc_ram (
    .clk(clk), .we(vc_we), .waddr(vc_wa), .wdata(vc_wd), .raddr(vc_ra), .rdata(vc_q)
  );
  wlit_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod_q));
  wlit_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      wlit_pkg::S_CLEAR:  if (last_clr) st_nxt = wlit_pkg::S_IDLE;
      wlit_pkg::S_IDLE:   if (in_acc) st_nxt = run_ok ? wlit_pkg::S_RD_OLD : wlit_pkg::S_OUT;
      wlit_pkg::S_RD_OLD: st_nxt = wlit_pkg::S_RD_NEW;
      wlit_pkg::S_RD_NEW: st_nxt = wlit_pkg::S_CMP;
      wlit_pkg::S_CMP:    st_nxt = exp_go ? wlit_pkg::S_E_MUL1 : wlit_pkg::S_UPD_A;
      wlit_pkg::S_E_MUL1: st_nxt = wlit_pkg::S_E_MUL2;
      wlit_pkg::S_E_MUL2: st_nxt = wlit_pkg::S_E_DIV;
      wlit_pkg::S_E_DIV:  st_nxt = (k_r == 4'd1) ? wlit_pkg::S_E_POW : wlit_pkg::S_E_MUL1;
      wlit_pkg::S_E_POW:  st_nxt = (n_r == 5'd0) ? wlit_pkg::S_UPD_A : wlit_pkg::S_E_POW2;
      wlit_pkg::S_E_POW2: st_nxt = wlit_pkg::S_E_POW;
      wlit_pkg::S_UPD_A:  st_nxt = wlit_pkg::S_UPD_W;
      wlit_pkg::S_UPD_W:  st_nxt = wlit_pkg::S_TWAIT;
      wlit_pkg::S_TWAIT: begin
        if (!drsp.busy) begin
          priority if (phase_r)              st_nxt = wlit_pkg::S_FIN;
          else if (step_r != 32'd0)          st_nxt = wlit_pkg::S_MWAIT;
          else                               st_nxt = wlit_pkg::S_MODCHK;
        end
      end
      wlit_pkg::S_MWAIT: begin
        if (!drsp.busy) begin
          st_nxt = (drsp.remainder == 32'd0) ? wlit_pkg::S_SWEEP : wlit_pkg::S_MODCHK;
        end
      end
      wlit_pkg::S_SWEEP: begin
        priority if (sweep_fail) st_nxt = wlit_pkg::S_MODCHK;
        else if (sweep_ok)       st_nxt = wlit_pkg::S_VCLR;
      end
      wlit_pkg::S_VCLR:   if (last_clr) st_nxt = wlit_pkg::S_MODCHK;
      wlit_pkg::S_MODCHK: st_nxt = wlit_pkg::S_FIN;
      wlit_pkg::S_FIN:    st_nxt = wlit_pkg::S_OUT;
      wlit_pkg::S_OUT:    if (out_free) st_nxt = wlit_pkg::S_IDLE;
      default:            st_nxt = wlit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ld_we = 1'b0;
    ld_wa = BW'(pres_r);
    ld_wd = (ld_sum[LW]) ? {LW{1'b1}} : ld_sum[LW-1:0];
    ld_ra = BW'(pres_r);
    vc_we = 1'b0;
    vc_wa = BW'(pres_r);
    vc_wd = (vc_q == 32'hFFFF_FFFF) ? vc_q : vc_q + 32'd1;
    vc_ra = BW'(pres_r);
    mul_a = p_r;
    mul_b = MW'(wlit_pkg::EXP_M1_Q32);
    dreq.start    = 1'b0;
    dreq.dividend = wlit_pkg::DVD_W'(nb) << F;
    dreq.divisor  = step_r;
    unique case (st_r)
      wlit_pkg::S_CLEAR: begin
        ld_we = 1'b1;
        ld_wa = clr_r;
        ld_wd = '0;
        vc_we = 1'b1;
        vc_wa = clr_r;
        vc_wd = '0;
      end
      wlit_pkg::S_RD_NEW: begin
        ld_ra = BW'(prop_r);
        dreq.start = 1'b1;
      end
      wlit_pkg::S_E_MUL1: begin
        mul_a = MW'(f_r);
        mul_b = p_r;
      end
      wlit_pkg::S_E_MUL2: begin
        mul_a = MW'(prod_q[63:32]);
        mul_b = wlit_pkg::recip(k_r);
      end
      wlit_pkg::S_UPD_W: begin
        ld_we = 1'b1;
        vc_we = 1'b1;
      end
      wlit_pkg::S_TWAIT: begin
        dreq.start    = !drsp.busy && !phase_r && (step_r != 32'd0);
        dreq.dividend = wlit_pkg::DVD_W'(step_r);
        dreq.divisor  = iv;
      end
      wlit_pkg::S_SWEEP: vc_ra = swp_r[BW-1:0];
      wlit_pkg::S_VCLR: begin
        vc_we = 1'b1;
        vc_wa = clr_r;
        vc_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wlit_pkg::S_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r     <= wlit_pkg::RST_BINS;
      occ_r      <= wlit_pkg::RST_INTERVAL;
      thr_r      <= wlit_pkg::RST_THRESHOLD;
      pristine_r <= 1'b1;
      pres_r     <= wlit_pkg::RST_START;
      mod_r      <= wlit_pkg::RST_INIT_MOD;
      step_r     <= '0;
      phase_r    <= 1'b0;
      done_r     <= 1'b0;
      clr_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          wlit_pkg::CFG_BINS_IN_USE: bins_r <= cfg_wdata[10:0];
          wlit_pkg::CFG_START_BIN: begin
            if (pristine_r) pres_r <= cfg_wdata[9:0];
          end
          wlit_pkg::CFG_INIT_MOD: begin
            if (pristine_r) mod_r <= cfg_wdata;
          end
          wlit_pkg::CFG_INTERVAL:  occ_r <= cfg_wdata;
          wlit_pkg::CFG_THRESHOLD: thr_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (st_r == wlit_pkg::S_OUT && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        wlit_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        wlit_pkg::S_IDLE: begin
          if (in_acc) begin
            if (32'(pres_r) >= nb32) pres_r <= 10'(nb - 1'b1);
            if (run_ok) pristine_r <= 1'b0;
          end
        end
        wlit_pkg::S_CMP: begin
          if (!prop_hi && (ld_q <= so_r)) pres_r <= prop_r;
        end
        wlit_pkg::S_E_POW: begin
          if (n_r == 5'd0 && (33'(rnd_r) < p_r)) pres_r <= prop_r;
        end
        wlit_pkg::S_TWAIT: begin
          if (!drsp.busy && phase_r) mod_r <= t_w;
        end
        wlit_pkg::S_SWEEP: begin
          if (!sweep_fail && sweep_ok) begin
            mod_r <= mod_r >> 1;
            clr_r <= '0;
          end
        end
        wlit_pkg::S_VCLR: clr_r <= clr_r + 1'b1;
        wlit_pkg::S_MODCHK: begin
          if (mod_r <= t_r && step_r > nb32) begin
            phase_r <= 1'b1;
            mod_r   <= t_r;
          end
        end
        wlit_pkg::S_FIN: begin
          if (mod_r < thr_r) done_r <= 1'b1;
          step_r <= step_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      wlit_pkg::S_IDLE: begin
        prop_r <= in_ch.proposed_bin;
        rnd_r  <= in_ch.random_uniform;
        acc_r  <= 1'b0;
      end
      wlit_pkg::S_RD_NEW: so_r <= ld_q;
      wlit_pkg::S_CMP: begin
        if (!prop_hi && (ld_q <= so_r)) acc_r <= 1'b1;
        f_r <= 32'(d_w[F-1:0]) << (32 - F);
        n_r <= 5'(d_w >> F);
        p_r <= MW'(1) << 32;
        k_r <= 4'd12;
      end
      wlit_pkg::S_E_MUL2: a_r <= prod_q[63:32];
      wlit_pkg::S_E_DIV: begin
        p_r <= (MW'(1) << 32) - MW'(q_fix);
        k_r <= k_r - 4'd1;
      end
      wlit_pkg::S_E_POW: begin
        if (n_r == 5'd0 && (33'(rnd_r) < p_r)) acc_r <= 1'b1;
      end
      wlit_pkg::S_E_POW2: begin
        p_r <= prod_q[64:32];
        n_r <= n_r - 5'd1;
      end
      wlit_pkg::S_TWAIT: t_r <= t_w;
      wlit_pkg::S_MWAIT: begin
        swp_r  <= '0;
        chkv_r <= 1'b0;
      end
      wlit_pkg::S_SWEEP: begin
        chkv_r <= 32'(swp_r) < nb32;
        if (swp_r != nb) swp_r <= swp_r + 1'b1;
      end
      wlit_pkg::S_OUT: begin
        if (out_free) begin
          o_acc_r   <= acc_r;
          o_bin_r   <= pres_r;
          o_phase_r <= phase_r;
          o_conv_r  <= done_r;
          o_lim_r   <= step_r >= wlit_pkg::STEP_LIMIT;
          o_mod_r   <= mod_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready               = st_r == wlit_pkg::S_IDLE;
  assign out_ch.valid              = ov_r;
  assign out_ch.accepted           = o_acc_r;
  assign out_ch.current_bin        = o_bin_r;
  assign out_ch.inverse_time_phase = o_phase_r;
  assign out_ch.converged          = o_conv_r;
  assign out_ch.limit_reached      = o_lim_r;
  assign out_ch.modification_now   = o_mod_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> done_r)
    else $error("convergence flag dropped");
  a_phase_sticky: assert property (@(posedge clk) disable iff (!rst_n) phase_r |=> phase_r)
    else $error("inverse-time phase left");
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready held after input transfer");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= wlit_pkg::STEP_LIMIT)
    else $error("step count past limit");
endmodule
